// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the parser RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define MCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by another.
`define MCP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/mcp_pkg.sv -----
// Types and constants for the MIDI channel message parser.
package mcp_pkg;

  localparam logic [7:0] SysexStart   = 8'hF0;
  localparam logic [7:0] SysexEnd     = 8'hF7;
  localparam logic [3:0] SystemNibble = 4'hF;
  localparam logic [3:0] TypeProgram  = 4'hC;
  localparam logic [3:0] TypePressure = 4'hD;
  localparam logic [3:0] TypeNoteOff  = 4'h8;
  localparam int unsigned StatusBit   = 7;

  // One input beat held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } mcp_beat_t;

  // One decoded channel message on its way to the result register.
  typedef struct packed {
    logic       valid;
    logic [3:0] channel;
    logic [3:0] message_type;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } mcp_result_t;

endpackage

// ----- rtl/mcp_in_stage.sv -----
// Input register that captures one raw MIDI byte per beat.
module mcp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         midi_byte_i,
  input  logic               advance_i,
  output mcp_pkg::mcp_beat_t beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       take;

  // The register is free when empty or when its byte moves on this cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // The byte itself needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= midi_byte_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;

endmodule

// ----- rtl/mcp_core.sv -----
// Running status state and single-pass decode of one MIDI byte.
`include "assert_macros.svh"

module mcp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcp_pkg::mcp_beat_t   beat_i,
  input  logic                 advance_i,
  output mcp_pkg::mcp_result_t result_o
);

  logic       in_sysex_q, in_sysex_d;
  logic       status_known_q, status_known_d;
  logic       first_pending_q, first_pending_d;
  logic [3:0] channel_q, channel_d;
  logic [3:0] type_q, type_d;
  logic [6:0] first_value_q, first_value_d;
  logic       take;
  logic [7:0] b;
  logic [3:0] hi;
  logic       one_byte_type;

  assign take          = beat_i.valid && advance_i;
  assign b             = beat_i.data;
  assign hi            = b[7:4];
  assign one_byte_type = (type_q == mcp_pkg::TypeProgram) || (type_q == mcp_pkg::TypePressure);

  // Decode one byte against the current running status.
  always_comb begin
    in_sysex_d           = in_sysex_q;
    status_known_d       = status_known_q;
    first_pending_d      = first_pending_q;
    channel_d            = channel_q;
    type_d               = type_q;
    first_value_d        = first_value_q;
    result_o.valid       = 1'b0;
    result_o.channel     = channel_q;
    result_o.message_type = type_q;
    result_o.data_first  = first_value_q;
    result_o.data_second = b[6:0];
    if (take) begin
      priority if (in_sysex_q && (b != mcp_pkg::SysexEnd)) begin
        // Everything inside system exclusive is skipped.
      end else if (hi == mcp_pkg::SystemNibble) begin
        if (b == mcp_pkg::SysexStart) begin
          in_sysex_d = 1'b1;
        end else if (b == mcp_pkg::SysexEnd) begin
          in_sysex_d = 1'b0;
        end
      end else if (b[mcp_pkg::StatusBit]) begin
        // A channel status byte starts a new running status.
        channel_d       = b[3:0];
        type_d          = hi;
        status_known_d  = 1'b1;
        first_pending_d = 1'b0;
      end else if (!status_known_q) begin
        // Data before any status byte is dropped.
      end else if (!first_pending_q) begin
        first_value_d = b[6:0];
        if (one_byte_type) begin
          result_o.valid       = 1'b1;
          result_o.data_first  = b[6:0];
          result_o.data_second = 7'd0;
        end else begin
          first_pending_d = 1'b1;
        end
      end else begin
        // Second data byte completes a two-byte message.
        result_o.valid  = 1'b1;
        first_pending_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sysex_q      <= 1'b0;
      status_known_q  <= 1'b0;
      first_pending_q <= 1'b0;
    end else begin
      in_sysex_q      <= in_sysex_d;
      status_known_q  <= status_known_d;
      first_pending_q <= first_pending_d;
    end
  end

  // Latched status and held data byte are only read once status is known.
  always_ff @(posedge clk_i) begin
    channel_q     <= channel_d;
    type_q        <= type_d;
    first_value_q <= first_value_d;
  end

  `MCP_ASSERT(a_pending_needs_status, clk_i, rst_ni, first_pending_q |-> status_known_q, "Data byte held without a known status.")
  `MCP_ASSERT(a_result_needs_status, clk_i, rst_ni, result_o.valid |-> (status_known_q && take), "Message emitted without a known status.")
  `MCP_ASSERT_NEXT(a_status_clears_pending, clk_i, rst_ni, take && !in_sysex_q && b[mcp_pkg::StatusBit] && (hi != mcp_pkg::SystemNibble), status_known_q && !first_pending_q, "Status byte did not restart running status.")

endmodule

// ----- rtl/mcp_out_stage.sv -----
// Result register that holds one decoded message until it is taken.
module mcp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcp_pkg::mcp_result_t result_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           channel_o,
  output logic [3:0]           message_type_o,
  output logic [6:0]           data_first_o,
  output logic [6:0]           data_second_o
);

  logic                 valid_q;
  mcp_pkg::mcp_result_t res_q;

  // The pipeline moves whenever this register is empty or being emptied.
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && result_i.valid) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign channel_o      = res_q.channel;
  assign message_type_o = res_q.message_type;
  assign data_first_o   = res_q.data_first;
  assign data_second_o  = res_q.data_second;

endmodule

// ----- rtl/midi_channel_message_parser_top.sv -----
// Top level of the MIDI channel message parser with running status.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-------------------------------------------------
//   in      | in_valid_i | in_stall_o  | midi_byte_i
//   out     | out_valid_o| out_stall_i | channel_o, message_type_o, data_first_o,
//           |            |             | data_second_o
//
// One byte is taken per cycle unless stalled; a message is valid from the result register.
// The rate is set by the single decode pass between the input and result registers.
// Reset clears the input and result valids and the running status; no data is kept.
// A stalled result holds the pipeline, and in_stall_o rises once the input register is full.
`include "assert_macros.svh"

module midi_channel_message_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] midi_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] channel_o,
  output logic [3:0] message_type_o,
  output logic [6:0] data_first_o,
  output logic [6:0] data_second_o
);

  mcp_pkg::mcp_beat_t   beat;
  mcp_pkg::mcp_result_t result;
  logic                 advance;

  mcp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .midi_byte_i (midi_byte_i),
    .advance_i   (advance),
    .beat_o      (beat)
  );

  mcp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .advance_i (advance),
    .result_o  (result)
  );

  mcp_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .result_i       (result),
    .advance_o      (advance),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_o      (channel_o),
    .message_type_o (message_type_o),
    .data_first_o   (data_first_o),
    .data_second_o  (data_second_o)
  );

  `MCP_ASSERT(a_type_is_channel_msg, clk_i, rst_ni,
              out_valid_o |-> ((message_type_o >= mcp_pkg::TypeNoteOff) &&
                               (message_type_o != mcp_pkg::SystemNibble)),
              "Result carries a non-channel message type.")
  `MCP_ASSERT(a_one_byte_second_zero, clk_i, rst_ni,
              (out_valid_o && ((message_type_o == mcp_pkg::TypeProgram) ||
                               (message_type_o == mcp_pkg::TypePressure))) |->
                (data_second_o == 7'd0),
              "One-byte message has a nonzero second data byte.")

endmodule

// ----- tb/tb_midi_channel_message_parser_top.sv -----
// Self-checking testbench for the MIDI channel message parser top level.
`timescale 1ns / 100ps

module tb_midi_channel_message_parser_top;

  localparam int MaxCycles   = 200000;
  localparam int DrainCycles = 12;
  localparam int RandomBytes = 505;
  localparam int HoldCycles  = 200;

  // One decoded channel message as seen on the output ports.
  typedef struct packed {
    logic [3:0] channel;
    logic [3:0] message_type;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } chan_msg_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] midi_byte_i = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [3:0] channel_o;
  logic [3:0] message_type_o;
  logic [6:0] data_first_o;
  logic [6:0] data_second_o;

  // Messages the parser must still deliver, oldest first.
  chan_msg_t expected_msgs[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  bytes_sent  = 0;
  int  hold_cycles = 0;
  bit  idle_en     = 1'b1;

  // Running status as the parser should be tracking it.
  bit         sx_active   = 1'b0;
  bit         status_seen = 1'b0;
  logic [3:0] run_channel = 4'h0;
  logic [3:0] run_type    = 4'h0;
  bit         held_valid  = 1'b0;
  logic [6:0] held_value  = 7'h00;

  midi_channel_message_parser_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .midi_byte_i    (midi_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_o      (channel_o),
    .message_type_o (message_type_o),
    .data_first_o   (data_first_o),
    .data_second_o  (data_second_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("midi_channel_message_parser_top test failed");
      $finish;
    end
  end

  // Update the running status for one accepted byte and queue any completed message.
  function automatic void decode_byte(input logic [7:0] b);
    chan_msg_t msg;
    if (sx_active && b != mcp_pkg::SysexEnd) return;
    if (b[7:4] == mcp_pkg::SystemNibble) begin
      if (b == mcp_pkg::SysexStart) sx_active = 1'b1;
      else if (b == mcp_pkg::SysexEnd) sx_active = 1'b0;
      return;
    end
    if (b[mcp_pkg::StatusBit]) begin
      run_channel = b[3:0];
      run_type    = b[7:4];
      status_seen = 1'b1;
      held_valid  = 1'b0;
      return;
    end
    if (!status_seen) return;
    if (!held_valid) begin
      held_value = b[6:0];
      if (run_type == mcp_pkg::TypeProgram || run_type == mcp_pkg::TypePressure) begin
        msg = '{run_channel, run_type, held_value, 7'd0};
        expected_msgs = {expected_msgs, msg};
      end else begin
        held_valid = 1'b1;
      end
      return;
    end
    msg = '{run_channel, run_type, held_value, b[6:0]};
    expected_msgs = {expected_msgs, msg};
    held_valid = 1'b0;
  endfunction

  // Offer one byte after a random gap and wait until the parser takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    midi_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Report one field mismatch.
  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Compare every accepted output beat with the oldest expected message.
  always @(posedge clk_i) begin
    chan_msg_t exp_msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_msgs.size() == 0) begin
        $display("%0t: unexpected message, expected none, actual ch %0h type %0h %0h %0h",
                 $time, channel_o, message_type_o, data_first_o, data_second_o);
        error_count++;
      end else begin
        exp_msg = expected_msgs.pop_front();
        check_field("channel", exp_msg.channel, channel_o);
        check_field("message_type", exp_msg.message_type, message_type_o);
        check_field("data_first", exp_msg.data_first, data_first_o);
        check_field("data_second", exp_msg.data_second, data_second_o);
      end
    end
  end

  // Output side: a random stall before each beat, or a long hold-off when requested.
  initial begin
    int k;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        k = idle_en ? $urandom_range(0, 3) : 0;
        if (k > 0) begin
          out_stall_i <= 1'b1;
          repeat (k) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && hold_cycles == 0);
    end
  end

  // Hand-picked stream covering each corner of the running status logic.
  task automatic test_directed();
    logic [7:0] seq [26];
    seq = '{
      8'h00, 8'h7F,                      // data before any status is dropped
      8'h90, 8'h3C, 8'h7F,               // note on
      8'h40, 8'h00,                      // running status
      8'hC5, 8'h7F,                      // program change, one data byte
      8'h80, 8'h10, 8'hEF, 8'h7F, 8'h7F, // new status drops the held byte
      8'hA1, 8'h11, 8'hF8, 8'hF1, 8'h22, // system bytes keep the held byte
      8'hF7,                             // stray end of exclusive
      8'hD0, 8'hF0, 8'h90, 8'hFF, 8'hF7, // exclusive block is skipped
      8'h55                              // channel pressure after exclusive
    };
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Mostly well-formed messages with random content, plus broken ones and noise.
  task automatic test_random_stream();
    int         kind;
    int         n;
    logic [7:0] b;
    n = bytes_sent + RandomBytes;
    while (bytes_sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // Complete message, status often reused.
        if (!status_seen || $urandom_range(0, 2) != 0)
          send_byte({4'($urandom_range(8, 14)), 4'($urandom)});
        for (int j = 0;
             j < ((run_type == mcp_pkg::TypeProgram ||
                   run_type == mcp_pkg::TypePressure) ? 1 : 2);
             j++) begin
          if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(8'hF1, 8'hFF)));
          send_byte({1'b0, 7'($urandom)});
        end
      end else if (kind < 80) begin
        // Truncated message, left hanging.
        send_byte({4'($urandom_range(8, 14)), 4'($urandom)});
        send_byte({1'b0, 7'($urandom)});
      end else if (kind < 88) begin
        // Exclusive block with random content.
        send_byte(mcp_pkg::SysexStart);
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom);
          if (b == mcp_pkg::SysexEnd) b = 8'h00;
          send_byte(b);
        end
        send_byte(mcp_pkg::SysexEnd);
      end else begin
        // Noise; a start of exclusive only comes from the blocks above.
        b = 8'($urandom);
        if (b == mcp_pkg::SysexStart) b = mcp_pkg::SysexEnd;
        send_byte(b);
      end
    end
  endtask

  // Back-to-back bytes with no gaps on either side.
  task automatic test_no_idle();
    idle_en = 1'b0;
    send_byte(8'hB7);
    repeat (60) send_byte({1'b0, 7'($urandom)});
    send_byte(8'hC2);
    repeat (20) send_byte({1'b0, 7'($urandom)});
    idle_en = 1'b1;
  endtask

  // Long receiver hold-off while the sender keeps offering note messages.
  task automatic test_backpressure();
    idle_en     = 1'b0;
    hold_cycles = HoldCycles;
    send_byte(8'h9A);
    repeat (80) send_byte({1'b0, 7'($urandom)});
    idle_en = 1'b1;
  endtask

  // Reset, the tests in turn, then drain and report.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_stream();
    test_no_idle();
    test_backpressure();
    test_random_stream();
    in_valid_i <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("midi_channel_message_parser_top test passed");
    end else begin
      $display("midi_channel_message_parser_top test failed");
    end
    $finish;
  end

endmodule
